@@ design/shc_pkg.sv @@
// Shared types and constants for the substring hash compare block.
`default_nettype none

package shc_pkg;

    localparam int unsigned DEFAULT_MAX_LEN = 4096;
    localparam int unsigned FIELD_W         = 12;
    localparam int unsigned HASH_W          = 30;

    localparam logic [HASH_W-1:0] HASH_MOD = 30'd1000000007;

    // input function codes
    localparam logic FUNC_APPEND = 1'b0;
    localparam logic FUNC_QUERY  = 1'b1;

    // queue entry kinds
    localparam logic [1:0] OP_LOAD  = 2'd0;
    localparam logic [1:0] OP_QUERY = 2'd1;
    localparam logic [1:0] OP_BAD   = 2'd2;

    typedef struct packed {
        logic               func;
        logic [7:0]         char_byte;
        logic [FIELD_W-1:0] first_start;
        logic [FIELD_W-1:0] first_end;
        logic [FIELD_W-1:0] second_start;
        logic [FIELD_W-1:0] second_end;
    } t_in_item;

    typedef struct packed {
        logic [HASH_W-1:0] first_hash;
        logic [HASH_W-1:0] second_hash;
        logic              hashes_equal;
        logic              range_error;
    } t_out_item;

    // classified work item: prefix and power addresses precomputed
    typedef struct packed {
        logic [1:0]         kind;
        logic [7:0]         char_byte;
        logic [FIELD_W-1:0] hi1;
        logic [FIELD_W-1:0] lo1m1;
        logic [FIELD_W-1:0] plen1;
        logic               lo1_zero;
        logic [FIELD_W-1:0] hi2;
        logic [FIELD_W-1:0] lo2m1;
        logic [FIELD_W-1:0] plen2;
        logic               lo2_zero;
    } t_op;

endpackage

`default_nettype wire

@@ design/shc_front.sv @@
// Front end: accepts input transfers, tracks loaded length, classifies items.
`default_nettype none

module shc_front #(
    parameter int unsigned MAX_LEN = shc_pkg::DEFAULT_MAX_LEN
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  shc_pkg::t_in_item i_in_data,
    input  logic             i_q_full,
    output logic             o_push,
    output shc_pkg::t_op     o_op
);
    import shc_pkg::*;

    localparam int unsigned LW = $clog2(MAX_LEN + 1);
    localparam int unsigned CW = (LW > FIELD_W) ? LW : FIELD_W;

    logic [LW-1:0] r_len;
    logic [LW-1:0] n_len;
    logic          accept;
    logic          is_load;
    logic          len_full;
    logic          bad;
    logic [CW-1:0] len_x;
    logic [CW-1:0] b_x;
    logic [CW-1:0] d_x;

    assign accept   = i_in_valid && !i_q_full;
    assign is_load  = (i_in_data.func == FUNC_APPEND);
    assign len_full = (r_len == LW'(MAX_LEN));

    assign len_x = CW'(r_len);
    assign b_x   = CW'(i_in_data.first_end);
    assign d_x   = CW'(i_in_data.second_end);

    assign bad = (i_in_data.first_start > i_in_data.first_end) || (b_x >= len_x) ||
                 (i_in_data.second_start > i_in_data.second_end) || (d_x >= len_x);

    assign o_in_stall = i_q_full;
    assign o_push     = accept && !(is_load && len_full);

    always_comb begin
        o_op.kind      = is_load ? OP_LOAD : (bad ? OP_BAD : OP_QUERY);
        o_op.char_byte = i_in_data.char_byte;
        o_op.hi1       = i_in_data.first_end;
        o_op.lo1m1     = i_in_data.first_start - 1'b1;
        o_op.plen1     = i_in_data.first_end - i_in_data.first_start + 1'b1;
        o_op.lo1_zero  = (i_in_data.first_start == '0);
        o_op.hi2       = i_in_data.second_end;
        o_op.lo2m1     = i_in_data.second_start - 1'b1;
        o_op.plen2     = i_in_data.second_end - i_in_data.second_start + 1'b1;
        o_op.lo2_zero  = (i_in_data.second_start == '0);
    end

    assign n_len = (accept && is_load && !len_full) ? r_len + 1'b1 : r_len;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len <= '0;
        end else begin
            r_len <= n_len;
        end
    end

endmodule

`default_nettype wire

@@ design/shc_queue.sv @@
// Two-entry queue of classified items between the front end and the back end.
`default_nettype none

module shc_queue (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  shc_pkg::t_op i_op,
    output logic         o_full,
    input  logic         i_pop,
    output logic         o_valid,
    output shc_pkg::t_op o_op
);
    import shc_pkg::*;

    localparam int unsigned DEPTH = 2;
    localparam int unsigned PW    = $clog2(DEPTH);
    localparam int unsigned CNTW  = $clog2(DEPTH + 1);

    t_op             r_mem [DEPTH];
    logic [PW-1:0]   r_wp;
    logic [PW-1:0]   r_rp;
    logic [CNTW-1:0] r_cnt;

    assign o_full  = (r_cnt == CNTW'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_op    = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_op;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

@@ design/shc_modmul.sv @@
// Pipelined modular multiplier, Barrett reduction, one issue per cycle.
`default_nettype none

module shc_modmul (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    input  logic [shc_pkg::HASH_W-1:0] i_x,
    input  logic [shc_pkg::HASH_W-1:0] i_y,
    output logic                      o_valid,
    output logic [shc_pkg::HASH_W-1:0] o_res
);
    import shc_pkg::*;

    localparam int unsigned PW   = 2 * HASH_W;
    localparam int unsigned MU_W = HASH_W + 1;
    localparam int unsigned QW   = 2 * MU_W;
    localparam int unsigned RW   = HASH_W + 2;
    localparam int unsigned LAT  = 5;
    localparam logic [63:0]     MU_WIDE = (64'd1 << PW) / 64'(HASH_MOD);
    localparam logic [MU_W-1:0] MU      = MU_WIDE[MU_W-1:0];

    logic [LAT-1:0]    r_v;
    logic [PW-1:0]     r_prod;
    logic [QW-1:0]     r_q2;
    logic [RW-1:0]     r_plo1;
    logic [RW-1:0]     r_plo2;
    logic [RW-1:0]     r_qm;
    logic [RW-1:0]     r_rem;
    logic [HASH_W-1:0] r_res;
    logic [MU_W-1:0]   q1;
    logic [MU_W-1:0]   q3;
    logic [RW-1:0]     m1;
    logic [RW-1:0]     m2;
    logic [RW-1:0]     fixed;

    assign q1 = r_prod[PW-1:HASH_W-1];
    assign q3 = r_q2[QW-1:HASH_W+1];
    assign m1 = RW'(HASH_MOD);
    assign m2 = m1 << 1;

    // remainder estimate is below 3M
    always_comb begin
        if (r_rem >= m2) begin
            fixed = r_rem - m2;
        end else if (r_rem >= m1) begin
            fixed = r_rem - m1;
        end else begin
            fixed = r_rem;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= PW'(i_x) * PW'(i_y);
        r_q2   <= QW'(q1) * QW'(MU);
        r_plo1 <= r_prod[RW-1:0];
        r_qm   <= RW'(q3) * RW'(HASH_MOD);
        r_plo2 <= r_plo1;
        r_rem  <= r_plo2 - r_qm;
        r_res  <= fixed[HASH_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            r_v <= {r_v[LAT-2:0], i_valid};
        end
    end

    assign o_valid = r_v[LAT-1];
    assign o_res   = r_res;

endmodule

`default_nettype wire

@@ design/shc_back.sv @@
// Back end: prefix and power memories, load and query sequencer, result register.
`default_nettype none

module shc_back #(
    parameter int unsigned MAX_LEN = shc_pkg::DEFAULT_MAX_LEN
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [shc_pkg::HASH_W-1:0] i_cfg_wdata,
    input  logic                       i_q_valid,
    input  shc_pkg::t_op               i_q_op,
    output logic                       o_pop,
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output shc_pkg::t_out_item         o_out_data
);
    import shc_pkg::*;

    localparam int unsigned IW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    localparam int unsigned LW = $clog2(MAX_LEN + 1);
    localparam int unsigned AW = (IW > FIELD_W) ? IW : FIELD_W;
    localparam logic [HASH_W-1:0] BASE_RESET = HASH_W'(257);

    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_RD0  = 4'd1;
    localparam logic [3:0] ST_RD1  = 4'd2;
    localparam logic [3:0] ST_RD2  = 4'd3;
    localparam logic [3:0] ST_RD3  = 4'd4;
    localparam logic [3:0] ST_RD4  = 4'd5;
    localparam logic [3:0] ST_MUL0 = 4'd6;
    localparam logic [3:0] ST_MUL1 = 4'd7;
    localparam logic [3:0] ST_WAIT = 4'd8;
    localparam logic [3:0] ST_FIN  = 4'd9;
    localparam logic [3:0] ST_OUT  = 4'd10;

    logic [3:0]         r_state;
    logic [3:0]         n_state;
    t_op                r_op;
    logic [HASH_W-1:0]  r_base;
    logic [HASH_W-1:0]  r_last_hash;
    logic [HASH_W-1:0]  r_last_pow;
    logic [LW-1:0]      r_wcnt;
    logic [HASH_W-1:0]  r_prefix_mem [MAX_LEN];
    logic [HASH_W-1:0]  r_power_mem [MAX_LEN];
    logic [HASH_W-1:0]  r_rd_prefix;
    logic [HASH_W-1:0]  r_rd_power;
    logic [HASH_W-1:0]  r_hb1;
    logic [HASH_W-1:0]  r_hb2;
    logic [HASH_W-1:0]  r_lo1;
    logic [HASH_W-1:0]  r_lo2;
    logic [HASH_W-1:0]  r_pw1;
    logic [HASH_W-1:0]  r_pw2;
    logic [HASH_W-1:0]  r_res0;
    logic [HASH_W-1:0]  r_res1;
    logic [HASH_W-1:0]  r_h1;
    logic [HASH_W-1:0]  r_h2;
    logic               r_got;
    logic               r_out_valid;
    t_out_item          r_out;

    logic [FIELD_W-1:0] p_sel;
    logic [FIELD_W-1:0] w_sel;
    logic [IW-1:0]      p_addr;
    logic [IW-1:0]      w_addr;
    logic [IW-1:0]      wr_addr;
    logic               mem_we;
    logic               is_first;
    logic               is_bad;
    logic               out_free;
    logic [HASH_W-1:0]  wr_hash;
    logic [HASH_W-1:0]  wr_pow;
    logic [HASH_W:0]    sum_load;
    logic [HASH_W:0]    diff1;
    logic [HASH_W:0]    diff2;
    logic [HASH_W:0]    mod_x;
    logic [HASH_W-1:0]  load_hash;
    logic [HASH_W-1:0]  h1;
    logic [HASH_W-1:0]  h2;
    logic               mm_valid;
    logic               mm_out_valid;
    logic [HASH_W-1:0]  mm_x;
    logic [HASH_W-1:0]  mm_y;
    logic [HASH_W-1:0]  mm_res;

    function automatic logic [IW-1:0] to_addr(input logic [FIELD_W-1:0] v);
        logic [AW-1:0] ext;
        ext = AW'(v);
        return ext[IW-1:0];
    endfunction

    assign is_first = (r_wcnt == '0);
    assign is_bad   = (r_op.kind == OP_BAD);
    assign out_free = !r_out_valid || !i_out_stall;
    assign o_pop    = (r_state == ST_IDLE) && i_q_valid;
    assign mem_we   = (r_state == ST_FIN) && (r_op.kind == OP_LOAD);
    assign wr_addr  = r_wcnt[IW-1:0];

    // read addresses for the four-read query sequence
    always_comb begin
        unique case (r_state)
            ST_RD0: begin
                p_sel = r_op.hi1;
                w_sel = r_op.plen1;
            end
            ST_RD1: begin
                p_sel = r_op.lo1m1;
                w_sel = r_op.plen2;
            end
            ST_RD2: begin
                p_sel = r_op.hi2;
                w_sel = r_op.plen2;
            end
            ST_RD3: begin
                p_sel = r_op.lo2m1;
                w_sel = r_op.plen2;
            end
            default: begin
                p_sel = r_op.hi1;
                w_sel = r_op.plen1;
            end
        endcase
    end

    assign p_addr = to_addr(p_sel);
    assign w_addr = to_addr(w_sel);

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_prefix_mem[wr_addr] <= wr_hash;
            r_power_mem[wr_addr]  <= wr_pow;
        end
        r_rd_prefix <= r_prefix_mem[p_addr];
        r_rd_power  <= r_power_mem[w_addr];
    end

    assign mod_x    = {1'b0, HASH_MOD};
    assign sum_load = {1'b0, r_res0} + (HASH_W + 1)'(r_op.char_byte);
    assign load_hash = (sum_load >= mod_x) ? HASH_W'(sum_load - mod_x) : sum_load[HASH_W-1:0];
    assign wr_hash  = is_first ? HASH_W'(r_op.char_byte) : load_hash;
    assign wr_pow   = is_first ? HASH_W'(1) : r_res1;

    assign diff1 = {1'b0, r_hb1} + mod_x - {1'b0, r_res0};
    assign diff2 = {1'b0, r_hb2} + mod_x - {1'b0, r_res1};
    assign h1    = (diff1 >= mod_x) ? HASH_W'(diff1 - mod_x) : diff1[HASH_W-1:0];
    assign h2    = (diff2 >= mod_x) ? HASH_W'(diff2 - mod_x) : diff2[HASH_W-1:0];

    // multiplier operands; a range starting at zero has no cut term
    assign mm_valid = (r_state == ST_MUL0) || (r_state == ST_MUL1);

    always_comb begin
        mm_x = r_last_hash;
        mm_y = r_base;
        if (r_op.kind == OP_LOAD) begin
            mm_x = (r_state == ST_MUL1) ? r_last_pow : r_last_hash;
        end else if (r_state == ST_MUL1) begin
            mm_x = r_op.lo2_zero ? '0 : r_lo2;
            mm_y = r_op.lo2_zero ? '0 : r_pw2;
        end else begin
            mm_x = r_op.lo1_zero ? '0 : r_lo1;
            mm_y = r_op.lo1_zero ? '0 : r_pw1;
        end
    end

    shc_modmul u_modmul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (mm_valid),
        .i_x     (mm_x),
        .i_y     (mm_y),
        .o_valid (mm_out_valid),
        .o_res   (mm_res)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_q_valid) begin
                    if (i_q_op.kind == OP_LOAD) begin
                        n_state = is_first ? ST_FIN : ST_MUL0;
                    end else if (i_q_op.kind == OP_QUERY) begin
                        n_state = ST_RD0;
                    end else begin
                        n_state = ST_OUT;
                    end
                end
            end
            ST_RD0:  n_state = ST_RD1;
            ST_RD1:  n_state = ST_RD2;
            ST_RD2:  n_state = ST_RD3;
            ST_RD3:  n_state = ST_RD4;
            ST_RD4:  n_state = ST_MUL0;
            ST_MUL0: n_state = ST_MUL1;
            ST_MUL1: n_state = ST_WAIT;
            ST_WAIT: begin
                if (mm_out_valid && r_got) begin
                    n_state = ST_FIN;
                end
            end
            ST_FIN: begin
                n_state = (r_op.kind == OP_LOAD) ? ST_IDLE : ST_OUT;
            end
            ST_OUT: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_base      <= BASE_RESET;
            r_wcnt      <= '0;
            r_got       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_base <= i_cfg_wdata;
            end
            if (mem_we) begin
                r_wcnt <= r_wcnt + 1'b1;
            end
            if (r_state == ST_MUL0) begin
                r_got <= 1'b0;
            end else if ((r_state == ST_WAIT) && mm_out_valid) begin
                r_got <= 1'b1;
            end
            if ((r_state == ST_OUT) && out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_op <= i_q_op;
        end
        unique case (r_state)
            ST_RD1: begin
                r_hb1 <= r_rd_prefix;
                r_pw1 <= r_rd_power;
            end
            ST_RD2: begin
                r_lo1 <= r_rd_prefix;
                r_pw2 <= r_rd_power;
            end
            ST_RD3: r_hb2 <= r_rd_prefix;
            ST_RD4: r_lo2 <= r_rd_prefix;
            ST_WAIT: begin
                if (mm_out_valid) begin
                    if (r_got) begin
                        r_res1 <= mm_res;
                    end else begin
                        r_res0 <= mm_res;
                    end
                end
            end
            ST_FIN: begin
                r_h1 <= h1;
                r_h2 <= h2;
                if (mem_we) begin
                    r_last_hash <= wr_hash;
                    r_last_pow  <= wr_pow;
                end
            end
            ST_OUT: begin
                if (out_free) begin
                    r_out.first_hash   <= is_bad ? '0 : r_h1;
                    r_out.second_hash  <= is_bad ? '0 : r_h2;
                    r_out.hashes_equal <= !is_bad && (r_h1 == r_h2);
                    r_out.range_error  <= is_bad;
                end
            end
            default: ;
        endcase
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

`default_nettype wire

@@ design/substring_hash_compare.sv @@
// Top level of the polynomial rolling hash substring comparator.
//
// Append items (func 0) extend the loaded string by one byte and store its prefix hash
// and base power modulo 1000000007; appends past MAX_LEN bytes are dropped. Query items
// (func 1) return the hashes of two inclusive zero-based ranges, an equal flag, and an
// error flag for reversed or out-of-length ranges. Items pass through a two-entry queue
// to a sequencer, so the input keeps taking transfers while earlier work and a waiting
// result are outstanding, until the queue is full. The first append skips the multiplier;
// each later append passes twice through the five-stage Barrett modular multiplier, once
// for the prefix hash and once for the base power. A valid query also passes through it
// twice after four reads through the single read port of the prefix memory.
// The prefix and power memories are not cleared after reset. hash_base is written
// through i_cfg_we/i_cfg_wdata and is applied to each byte as it is appended.
`default_nettype none

module substring_hash_compare #(
    parameter int unsigned MAX_LEN = shc_pkg::DEFAULT_MAX_LEN
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  shc_pkg::t_in_item          i_in_data,
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output shc_pkg::t_out_item         o_out_data,
    input  logic                       i_cfg_we,
    input  logic [shc_pkg::HASH_W-1:0] i_cfg_wdata
);
    import shc_pkg::*;

    logic q_push;
    logic q_full;
    logic q_pop;
    logic q_valid;
    t_op  front_op;
    t_op  head_op;

    shc_front #(
        .MAX_LEN (MAX_LEN)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_data  (i_in_data),
        .i_q_full   (q_full),
        .o_push     (q_push),
        .o_op       (front_op)
    );

    shc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_op    (front_op),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_op    (head_op)
    );

    shc_back #(
        .MAX_LEN (MAX_LEN)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_q_valid   (q_valid),
        .i_q_op      (head_op),
        .o_pop       (q_pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

endmodule

`default_nettype wire

@@ design/shc_checker.sv @@
// Port-level checks for substring_hash_compare and their bind.
`default_nettype none

module shc_checker (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       o_out_valid,
    input logic                       i_out_stall,
    input shc_pkg::t_out_item         o_out_data
);
    import shc_pkg::*;

    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("stalled result changed");

    a_error_zeroed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.range_error |->
            o_out_data.first_hash == '0 && o_out_data.second_hash == '0 &&
            !o_out_data.hashes_equal)
        else $error("range error result not zeroed");

    a_equal_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_data.range_error |->
            o_out_data.hashes_equal == (o_out_data.first_hash == o_out_data.second_hash))
        else $error("equal flag disagrees with hashes");

    a_hash_reduced: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_data.first_hash < HASH_MOD && o_out_data.second_hash < HASH_MOD)
        else $error("hash not reduced");

endmodule

bind substring_hash_compare shc_checker u_shc_checker (.*);

`default_nettype wire
